// ===== design/csht_pkg.sv =====
// Shared types, constants and helpers of the contention stack hash table.
`default_nettype none
package csht_pkg;

    localparam int ENTRIES = 1024;   // table slots, a power of two
    localparam int PROBES  = 4;      // slots tried per event
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int SCAN_W  = ADDR_W + 1;
    localparam int PROBE_W = (PROBES > 1) ? $clog2(PROBES) : 1;

    localparam logic [30:0] THRESH_RST = 31'd2000000;

    localparam logic [1:0] OP_EVENT   = 2'd0;
    localparam logic [1:0] OP_COLLECT = 2'd1;
    localparam logic [1:0] OP_DRAIN   = 2'd2;

    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;

    localparam logic CFG_PROFILING = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] stack_hash;
        logic [63:0] stack_signature;
        logic [62:0] lock_wait;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_status;
        logic        long_wait;
        logic        entry_found;
        logic [63:0] entry_signature;
        logic [62:0] entry_count;
        logic [62:0] entry_cycles;
        logic [62:0] dropped_samples;
        logic [62:0] total_wait_cycles;
    } t_out;

    typedef struct packed {
        logic [62:0] count;
        logic [62:0] cycles;
    } t_slot_cnt;

    typedef struct packed {
        logic [63:0] hash;
        logic [63:0] signature;
    } t_slot_key;

    // Saturating 63-bit add.
    function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? {63{1'b1}} : s[62:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/csht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/contention_stack_hash_table.sv =====
// Contention stack hash table: sequencer, slot memories and result register.
// After reset the block clears its counts memory, one slot per cycle, and holds
// o_in_ready low until that pass is done. It then takes one transaction at a
// time through a small sequencer around a shared saturating 63-bit adder and a
// counts/key memory pair read one slot per cycle. An event goes from dispatch
// to finish, where its result is loaded, through a probe of 1 to PROBES slots
// when profiling is on; an unprofiled event, a drain or an unused opcode goes
// from dispatch straight to finish; a collect walks slots up to the rest of the
// table. The result sits in an output register, and a new transaction is taken
// as soon as the sequencer is back in idle, even while that result waits.
`default_nettype none
module contention_stack_hash_table (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  csht_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output csht_pkg::t_out    o_out_data,
    input  wire               i_cfg_we,
    input  wire               i_cfg_index,
    input  wire [30:0]        i_cfg_data
);
    import csht_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_PROBE    = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [PROBE_W-1:0]  r_probe, n_probe;
    logic [SCAN_W-1:0]   r_scan, n_scan;
    logic [62:0]         r_wait, n_wait;
    logic [62:0]         r_dropped, n_dropped;
    logic                r_addw, n_addw;
    logic                r_prof;
    logic [30:0]         r_thresh;
    t_in                 r_item, n_item;
    t_out                r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                cnt_we, key_we;
    t_slot_cnt           cnt_wdata, cnt_rdata;
    t_slot_key           key_wdata, key_rdata;

    logic [62:0]         add_a, add_sum;
    logic                slot_free, slot_match, out_free, long_wait;

    csht_ram #(.WIDTH($bits(t_slot_cnt)), .DEPTH(ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_idx),
        .i_wdata (cnt_wdata),
        .i_raddr (n_idx),
        .o_rdata (cnt_rdata)
    );

    csht_ram #(.WIDTH($bits(t_slot_key)), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_idx),
        .i_wdata (key_wdata),
        .i_raddr (n_idx),
        .o_rdata (key_rdata)
    );

    // One shared saturating adder: slot cycles while probing, wait total otherwise.
    assign add_a   = (r_state == S_PROBE) ? cnt_rdata.cycles : r_wait;
    assign add_sum = sat_add63(add_a, r_item.lock_wait);

    assign slot_free  = (cnt_rdata.count == '0);
    assign slot_match = (key_rdata.hash == r_item.stack_hash) &&
                        (key_rdata.signature == r_item.stack_signature);
    assign out_free   = !r_out_valid || i_out_ready;
    assign long_wait  = (r_item.lock_wait > {32'd0, r_thresh});

    assign key_wdata  = '{hash: r_item.stack_hash, signature: r_item.stack_signature};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_probe     = r_probe;
        n_scan      = r_scan;
        n_wait      = r_wait;
        n_dropped   = r_dropped;
        n_addw      = r_addw;
        n_item      = r_item;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        cnt_we      = 1'b0;
        key_we      = 1'b0;
        cnt_wdata   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                cnt_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == ADDR_W'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res = '0;
                n_res.event_status = ST_NONE;
                n_addw  = 1'b0;
                n_state = S_FINISH;
                unique case (r_item.opcode)
                    OP_EVENT: begin
                        n_res.long_wait = long_wait;
                        n_addw = r_prof || long_wait;
                        if (r_prof) begin
                            n_idx   = r_item.stack_hash[ADDR_W-1:0];
                            n_probe = '0;
                            n_state = S_PROBE;
                        end
                    end
                    OP_COLLECT: begin
                        if (r_scan[ADDR_W]) begin
                            n_scan = '0;
                        end else begin
                            n_idx   = r_scan[ADDR_W-1:0];
                            n_state = S_SCAN;
                        end
                    end
                    OP_DRAIN: begin
                        n_res.dropped_samples = r_dropped;
                        n_dropped = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_PROBE: begin
                if (slot_free || slot_match) begin
                    cnt_we    = 1'b1;
                    key_we    = slot_free;
                    cnt_wdata = '{count: sat_add63(cnt_rdata.count, 63'd1), cycles: add_sum};
                    n_res.event_status = ST_RECORDED;
                    n_state = S_FINISH;
                end else if (r_probe == PROBE_W'(PROBES - 1)) begin
                    n_dropped = sat_add63(r_dropped, 63'd1);
                    n_res.event_status = ST_DROPPED;
                    n_state = S_FINISH;
                end else begin
                    // advance to the next slot in line
                    n_probe = r_probe + 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                if (!slot_free) begin
                    cnt_we = 1'b1;
                    n_res.entry_found     = 1'b1;
                    n_res.entry_signature = key_rdata.signature;
                    n_res.entry_count     = cnt_rdata.count;
                    n_res.entry_cycles    = cnt_rdata.cycles;
                    n_scan  = {1'b0, r_idx} + SCAN_W'(1);
                    n_state = S_FINISH;
                end else if (r_idx == ADDR_W'(ENTRIES - 1)) begin
                    n_scan  = '0;
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (out_free) begin
                    if (r_addw) begin
                        n_wait = add_sum;
                    end
                    n_out = r_res;
                    n_out.total_wait_cycles = r_addw ? add_sum : r_wait;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_probe     <= '0;
            r_scan      <= '0;
            r_wait      <= '0;
            r_dropped   <= '0;
            r_addw      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prof      <= 1'b0;
            r_thresh    <= THRESH_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_probe     <= n_probe;
            r_scan      <= n_scan;
            r_wait      <= n_wait;
            r_dropped   <= n_dropped;
            r_addw      <= n_addw;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PROFILING: r_prof   <= i_cfg_data[0];
                    CFG_THRESHOLD: r_thresh <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_W'(ENTRIES))
        else $error("scan index beyond table");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_probe <= PROBE_W'(PROBES - 1)))
        else $error("probe counter beyond probe limit");

    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_FINISH))
        else $error("result loaded outside finish step");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.entry_found) |-> (r_out.event_status == ST_NONE))
        else $error("collected entry carries an event status");
`endif

endmodule
`default_nettype wire
